>>> src/afcc_pkg.sv
package afcc_pkg;

    localparam logic [7:0] CRC_POLY = 8'h1D;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [15:0] CENTER_FLIP = 16'h8000;

    localparam logic [7:0] CMD_HIGH_RESET = 8'd128;
    localparam logic [7:0] CMD_LOW_RESET = 8'd33;

    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t CFG_CMD_HIGH = 1'b0;
    localparam cfg_index_t CFG_CMD_LOW = 1'b1;

    // reply byte position inside one frame
    typedef enum logic [1:0] {
        POS_ANGLE_HI = 2'd0,
        POS_ANGLE_LO = 2'd1,
        POS_STATUS = 2'd2,
        POS_CRC = 2'd3
    } pos_t;

    // control from the frame sequencer to the crc step
    typedef struct packed {
        logic restart;
        logic update;
    } crc_ctl_t;

    typedef struct packed {
        logic [7:0] cmd_high;
        logic [7:0] cmd_low;
    } cmd_t;

    // msb-first crc-8 over one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> src/afcc_crc_step.sv
module afcc_crc_step (
    input  afcc_pkg::crc_ctl_t ctl,
    input  afcc_pkg::cmd_t     cmd,
    input  logic [7:0]         crc_in,
    input  logic [7:0]         data,
    output logic [7:0]         crc_out
);
    import afcc_pkg::*;

    logic [7:0] seed;
    logic [7:0] base;

    // seed is init run over both command bytes
    assign seed = crc8_byte(crc8_byte(CRC_INIT, cmd.cmd_high), cmd.cmd_low);
    assign base = ctl.restart ? seed : crc_in;
    assign crc_out = ctl.update ? crc8_byte(base, data) : base;

endmodule

>>> src/angle_frame_crc_check.sv
// channel  | dir | tdata (low bit up)                                  | tuser
// s_       | in  | rx_byte[7:0]                                        | frame_start
// m_       | out | angle_word, angle_centered, status_byte, crc_ok, 0s | -
// cfg_     | in  | cfg_index 0 = command_high, 1 = command_low         | -
//
// one item per cycle sustained unless a frame end waits on a stalled result;
// the crc byte passes the input register, then the result register
// the crc step, the command-byte seed and the compare sit between the input
// register and the frame state / result register
// synchronous active-low reset clears position, crc seed state and captures
// a stalled result holds in the result register; the input register keeps
// taking items until a second frame end would overwrite a waiting result
module angle_frame_crc_check (
    input  logic        aclk,
    input  logic        aresetn,
    // rx_byte[7:0]
    input  logic [7:0]  s_tdata,
    // frame_start
    input  logic        s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // angle_word[15:0], angle_centered[31:16], status_byte[39:32], crc_ok[40], zero pad
    output logic [47:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import afcc_pkg::*;

    // configuration
    cmd_t cmd_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    // frame state
    pos_t        pos_reg;
    logic [7:0]  crc_acc_reg;
    logic [15:0] angle_cap_reg;
    logic [7:0]  status_cap_reg;
    logic [15:0] last_good_reg;

    // result register
    logic        out_valid_reg;
    logic [15:0] out_word_reg;
    logic [7:0]  out_status_reg;
    logic        out_ok_reg;

    pos_t       pos_eff;
    crc_ctl_t   crc_ctl;
    logic [7:0] crc_next;
    logic       produce;
    logic       advance;
    logic       crc_ok;
    logic [15:0] word_next;

    // frame start or wrap after the crc byte both begin at the angle high byte
    always_comb begin
        pos_eff = in_start_reg ? POS_ANGLE_HI : pos_reg;
        crc_ctl.restart = (pos_eff == POS_ANGLE_HI);
        crc_ctl.update = (pos_eff == POS_ANGLE_HI) || (pos_eff == POS_ANGLE_LO);
        produce = (pos_eff == POS_CRC);
        crc_ok = ((~crc_acc_reg) == in_byte_reg);
        word_next = crc_ok ? angle_cap_reg : last_good_reg;
        // move the held item on unless it ends a frame and the result is stuck
        advance = in_valid_reg && (!produce || !out_valid_reg || m_tready);
    end

    assign s_tready = !in_valid_reg || advance;

    afcc_crc_step u_crc (
        .ctl     (crc_ctl),
        .cmd     (cmd_reg),
        .crc_in  (crc_acc_reg),
        .data    (in_byte_reg),
        .crc_out (crc_next)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg.cmd_high <= CMD_HIGH_RESET;
            cmd_reg.cmd_low <= CMD_LOW_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CMD_HIGH: cmd_reg.cmd_high <= cfg_data;
                CFG_CMD_LOW:  cmd_reg.cmd_low <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    // frame state; the accumulator only matters once restarted at byte 0
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_ANGLE_HI;
            crc_acc_reg <= CRC_INIT;
            angle_cap_reg <= '0;
            status_cap_reg <= '0;
            last_good_reg <= '0;
        end else if (advance) begin
            crc_acc_reg <= crc_next;
            unique case (pos_eff)
                POS_ANGLE_HI: begin
                    angle_cap_reg[15:8] <= in_byte_reg;
                    pos_reg <= POS_ANGLE_LO;
                end
                POS_ANGLE_LO: begin
                    angle_cap_reg[7:0] <= in_byte_reg;
                    pos_reg <= POS_STATUS;
                end
                POS_STATUS: begin
                    status_cap_reg <= in_byte_reg;
                    pos_reg <= POS_CRC;
                end
                POS_CRC: begin
                    if (crc_ok) begin
                        last_good_reg <= angle_cap_reg;
                    end
                    pos_reg <= POS_ANGLE_HI;
                end
                default: pos_reg <= POS_ANGLE_HI;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && produce) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && produce) begin
            out_word_reg <= word_next;
            out_status_reg <= status_cap_reg;
            out_ok_reg <= crc_ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {7'b0, out_ok_reg, out_status_reg, out_word_reg ^ CENTER_FLIP, out_word_reg};

endmodule
